### rtl/boundary_tag_heap_allocator_macros.svh
// assertion macros shared by the heap allocator rtl
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BTHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap allocator check failed");
// next-cycle implication
`define BTHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap allocator check failed");
`else
`define BTHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BTHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/btha_pkg.sv
// types, codes and constants of the heap allocator
package btha_pkg;

    localparam int HEAP_BYTES_DEF = 127;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_BAD_ADDR = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        TAG_HDR1 = 2'd0,
        TAG_FTR1 = 2'd1,
        TAG_HDR2 = 2'd2,
        TAG_FTR2 = 2'd3
    } t_tag_sel;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     clr_step;
        logic     latch;
        logic     rd_j;
        logic     rd_end;
        logic     rd_addr;
        logic     step;
        logic     set_alloc;
        logic     set_span;
        logic     ext_end;
        logic     zero_step;
        logic     set_free_tags;
        logic     tag_wr;
        t_tag_sel tag_sel;
        logic     wr_byte;
        logic     finish;
        t_status  status;
        logic     pa_sel;
        logic     rd_sel;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        t_action op;
        logic    clr_last;
        logic    j_end;
        logic    blk_ok;
        logic    blk_alloc;
        logic    fits;
        logic    split;
        logic    hit;
        logic    end_end;
        logic    nxt_free_ok;
        logic    zero_done;
        logic    addr_bad;
    } t_dp_stat;

    // boundary tag: size in the upper bits, allocated flag in bit 0
    function automatic logic [7:0] make_tag(input logic [6:0] sz, input logic al);
        return {sz, al};
    endfunction

endpackage

### rtl/btha_ram.sv
// generic simple dual port ram with registered read
module btha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 127
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/btha_ctrl.sv
// sequencing state machine of the heap allocator
`include "boundary_tag_heap_allocator_macros.svh"

module btha_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  btha_pkg::t_dp_stat i_stat,
    output btha_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_WALK_RD = 13'b0000000000100,
        S_WALK_EV = 13'b0000000001000,
        S_NEXT_RD = 13'b0000000010000,
        S_NEXT_EV = 13'b0000000100000,
        S_ZERO    = 13'b0000001000000,
        S_TAG0    = 13'b0000010000000,
        S_TAG1    = 13'b0000100000000,
        S_TAG2    = 13'b0001000000000,
        S_TAG3    = 13'b0010000000000,
        S_BYTE    = 13'b0100000000000,
        S_BYTE_EV = 13'b1000000000000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    btha_pkg::t_dp_cmd cmd;
    logic              is_alloc;

    assign is_alloc = (i_stat.op == btha_pkg::ACT_ALLOC);

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    cmd.latch = 1'b1;
                    n_state   = S_BYTE;
                end
            end
            S_WALK_RD: begin
                if (i_stat.j_end) begin
                    cmd.finish = 1'b1;
                    cmd.status = is_alloc ? btha_pkg::ST_NO_FIT : btha_pkg::ST_BAD_ADDR;
                    n_state    = S_IDLE;
                end else begin
                    cmd.rd_j = 1'b1;
                    n_state  = S_WALK_EV;
                end
            end
            S_WALK_EV: begin
                if (!i_stat.blk_ok) begin
                    cmd.finish = 1'b1;
                    cmd.status = is_alloc ? btha_pkg::ST_NO_FIT : btha_pkg::ST_BAD_ADDR;
                    n_state    = S_IDLE;
                end else if (is_alloc) begin
                    if (!i_stat.blk_alloc && i_stat.fits) begin
                        cmd.set_alloc = 1'b1;
                        n_state       = S_TAG0;
                    end else begin
                        cmd.step = 1'b1;
                        n_state  = S_WALK_RD;
                    end
                end else if (i_stat.hit) begin
                    if (i_stat.blk_alloc) begin
                        cmd.set_span = 1'b1;
                        n_state      = S_NEXT_RD;
                    end else begin
                        cmd.finish = 1'b1;
                        cmd.status = btha_pkg::ST_BAD_ADDR;
                        n_state    = S_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                    n_state  = S_WALK_RD;
                end
            end
            S_NEXT_RD: begin
                if (i_stat.end_end) begin
                    n_state = S_ZERO;
                end else begin
                    cmd.rd_end = 1'b1;
                    n_state    = S_NEXT_EV;
                end
            end
            S_NEXT_EV: begin
                cmd.ext_end = i_stat.nxt_free_ok;
                n_state     = S_ZERO;
            end
            S_ZERO: begin
                if (i_stat.zero_done) begin
                    cmd.set_free_tags = 1'b1;
                    n_state           = S_TAG0;
                end else begin
                    cmd.zero_step = 1'b1;
                end
            end
            S_TAG0: begin
                cmd.tag_wr  = 1'b1;
                cmd.tag_sel = btha_pkg::TAG_HDR1;
                n_state     = S_TAG1;
            end
            S_TAG1: begin
                cmd.tag_wr  = 1'b1;
                cmd.tag_sel = btha_pkg::TAG_FTR1;
                if (i_stat.split) begin
                    n_state = S_TAG2;
                end else begin
                    cmd.finish = 1'b1;
                    cmd.status = btha_pkg::ST_OK;
                    cmd.pa_sel = is_alloc;
                    n_state    = S_IDLE;
                end
            end
            S_TAG2: begin
                cmd.tag_wr  = 1'b1;
                cmd.tag_sel = btha_pkg::TAG_HDR2;
                n_state     = S_TAG3;
            end
            S_TAG3: begin
                cmd.tag_wr  = 1'b1;
                cmd.tag_sel = btha_pkg::TAG_FTR2;
                cmd.finish  = 1'b1;
                cmd.status  = btha_pkg::ST_OK;
                cmd.pa_sel  = 1'b1;
                n_state     = S_IDLE;
            end
            S_BYTE: begin
                if (i_stat.op == btha_pkg::ACT_ALLOC || i_stat.op == btha_pkg::ACT_FREE) begin
                    n_state = S_WALK_RD;
                end else if (i_stat.addr_bad) begin
                    cmd.finish = 1'b1;
                    cmd.status = btha_pkg::ST_BAD_ADDR;
                    n_state    = S_IDLE;
                end else if (i_stat.op == btha_pkg::ACT_WRITE) begin
                    cmd.wr_byte = 1'b1;
                    cmd.finish  = 1'b1;
                    cmd.status  = btha_pkg::ST_OK;
                    n_state     = S_IDLE;
                end else begin
                    cmd.rd_addr = 1'b1;
                    n_state     = S_BYTE_EV;
                end
            end
            S_BYTE_EV: begin
                cmd.finish = 1'b1;
                cmd.status = btha_pkg::ST_OK;
                cmd.rd_sel = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_cmd = cmd;

    // a finished item always hands control back to idle
    `BTHA_ASSERT_NXT(a_finish_to_idle, i_clk, i_rst_n, cmd.finish, r_state == S_IDLE)

endmodule

### rtl/btha_dp.sv
// heap store, walk registers and result registers of the heap allocator
`include "boundary_tag_heap_allocator_macros.svh"

module btha_dp #(
    parameter int HEAP_BYTES = btha_pkg::HEAP_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_action,
    input  logic [6:0]         i_size,
    input  logic [6:0]         i_address,
    input  logic [7:0]         i_wdata,
    input  btha_pkg::t_dp_cmd  i_cmd,
    output btha_pkg::t_dp_stat o_stat,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [6:0]         o_payload_addr,
    output logic [7:0]         o_rdata
);

    localparam int         AW       = $clog2(HEAP_BYTES);
    localparam logic [7:0] HEAP_END = 8'(HEAP_BYTES);
    localparam logic [7:0] INIT_TAG = 8'(HEAP_BYTES * 2);

    btha_pkg::t_action r_op;
    logic [6:0]        r_size;
    logic [6:0]        r_addr;
    logic [7:0]        r_wdata;
    logic [7:0]        r_j;
    logic [7:0]        r_prev;
    logic              r_has_prev;
    logic              r_prev_free;
    logic [7:0]        r_start;
    logic [7:0]        r_end;
    logic [7:0]        r_h;
    logic [7:0]        r_clr;
    logic [7:0]        r_b1_a;
    logic [6:0]        r_b1_sz;
    logic              r_b1_al;
    logic [7:0]        r_b2_a;
    logic [6:0]        r_b2_sz;
    logic              r_split;
    logic [6:0]        r_pa;
    logic              r_valid;
    logic [1:0]        r_status;
    logic [6:0]        r_res_pa;
    logic [7:0]        r_res_rd;

    logic [7:0] w_rd;
    logic [6:0] w_bs;
    logic [7:0] w_sum;
    logic [7:0] w_nsum;
    logic [7:0] w_need;
    logic [7:0] w_rest;
    logic [7:0] w_span_start;
    logic       w_we;
    logic [7:0] w_waddr;
    logic [7:0] w_wval;
    logic       w_re;
    logic [7:0] w_raddr;

    // header under evaluation
    assign w_bs         = w_rd[7:1];
    assign w_sum        = r_j + {1'b0, w_bs};
    assign w_nsum       = r_end + {1'b0, w_bs};
    assign w_need       = {1'b0, r_size} + 8'd2;
    assign w_rest       = {1'b0, w_bs} - w_need;
    assign w_span_start = (r_has_prev && r_prev_free) ? r_prev : r_j;

    assign o_stat.op          = r_op;
    assign o_stat.clr_last    = (r_clr == HEAP_END - 8'd1);
    assign o_stat.j_end       = (r_j >= HEAP_END);
    assign o_stat.blk_ok      = (w_bs >= 7'd2) && (w_sum <= HEAP_END);
    assign o_stat.blk_alloc   = w_rd[0];
    assign o_stat.fits        = ({1'b0, w_bs} >= w_need);
    assign o_stat.split       = r_split;
    assign o_stat.hit         = ((r_j + 8'd1) == {1'b0, r_addr});
    assign o_stat.end_end     = (r_end >= HEAP_END);
    assign o_stat.nxt_free_ok = (w_bs >= 7'd2) && (w_nsum <= HEAP_END) && !w_rd[0];
    assign o_stat.zero_done   = ((r_h + 8'd1) >= r_end);
    assign o_stat.addr_bad    = ({1'b0, r_addr} >= HEAP_END);

    // write port select
    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_j;
        w_wval  = 8'd0;
        priority if (i_cmd.clr_step) begin
            w_waddr = r_clr;
            w_wval  = (r_clr == 8'd0 || r_clr == HEAP_END - 8'd1) ? INIT_TAG : 8'd0;
        end else if (i_cmd.zero_step) begin
            w_waddr = r_h;
        end else if (i_cmd.tag_wr) begin
            unique case (i_cmd.tag_sel)
                btha_pkg::TAG_HDR1: begin
                    w_waddr = r_b1_a;
                    w_wval  = btha_pkg::make_tag(r_b1_sz, r_b1_al);
                end
                btha_pkg::TAG_FTR1: begin
                    w_waddr = r_b1_a + {1'b0, r_b1_sz} - 8'd1;
                    w_wval  = btha_pkg::make_tag(r_b1_sz, r_b1_al);
                end
                btha_pkg::TAG_HDR2: begin
                    w_waddr = r_b2_a;
                    w_wval  = btha_pkg::make_tag(r_b2_sz, 1'b0);
                end
                btha_pkg::TAG_FTR2: begin
                    w_waddr = r_b2_a + {1'b0, r_b2_sz} - 8'd1;
                    w_wval  = btha_pkg::make_tag(r_b2_sz, 1'b0);
                end
                default: begin
                    w_waddr = r_b1_a;
                end
            endcase
        end else if (i_cmd.wr_byte) begin
            w_waddr = {1'b0, r_addr};
            w_wval  = r_wdata;
        end else begin
            w_we = 1'b0;
        end
    end

    // read port select
    always_comb begin
        w_re = i_cmd.rd_j || i_cmd.rd_end || i_cmd.rd_addr;
        priority if (i_cmd.rd_end) begin
            w_raddr = r_end;
        end else if (i_cmd.rd_addr) begin
            w_raddr = {1'b0, r_addr};
        end else begin
            w_raddr = r_j;
        end
    end

    btha_ram #(
        .WIDTH (8),
        .DEPTH (HEAP_BYTES)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[AW-1:0]),
        .i_wdata (w_wval),
        .i_re    (w_re),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= 8'd0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + 8'd1;
            end
            r_valid <= i_cmd.finish;
        end
    end

    // walk and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op       <= btha_pkg::t_action'(i_action);
            r_size     <= i_size;
            r_addr     <= i_address;
            r_wdata    <= i_wdata;
            r_j        <= 8'd0;
            r_has_prev <= 1'b0;
        end
        if (i_cmd.step) begin
            r_prev      <= r_j;
            r_has_prev  <= 1'b1;
            r_prev_free <= !w_rd[0];
            r_j         <= w_sum;
        end
        if (i_cmd.set_alloc) begin
            r_b1_a  <= r_j;
            r_b1_sz <= (w_rest >= 8'd2) ? w_need[6:0] : w_bs;
            r_b1_al <= 1'b1;
            r_b2_a  <= r_j + w_need;
            r_b2_sz <= w_rest[6:0];
            r_split <= (w_rest >= 8'd2);
            r_pa    <= 7'(r_j + 8'd1);
        end
        if (i_cmd.set_span) begin
            r_start <= w_span_start;
            r_h     <= w_span_start + 8'd1;
            r_end   <= w_sum;
        end
        if (i_cmd.ext_end) begin
            r_end <= w_nsum;
        end
        if (i_cmd.zero_step) begin
            r_h <= r_h + 8'd1;
        end
        if (i_cmd.set_free_tags) begin
            r_b1_a  <= r_start;
            r_b1_sz <= 7'(r_end - r_start);
            r_b1_al <= 1'b0;
            r_split <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.status;
            r_res_pa <= i_cmd.pa_sel ? r_pa : 7'd0;
            r_res_rd <= i_cmd.rd_sel ? w_rd : 8'd0;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_payload_addr = r_res_pa;
    assign o_rdata        = r_res_rd;

    // no write ever lands outside the heap
    `BTHA_ASSERT_IMP(a_write_in_heap, i_clk, i_rst_n, w_we, w_waddr < HEAP_END)
    // a failed action returns no address and no data
    `BTHA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, r_valid && r_status != btha_pkg::ST_OK, r_res_pa == 7'd0 && r_res_rd == 8'd0)

endmodule

### rtl/boundary_tag_heap_allocator.sv
// top level of the boundary tag heap allocator
//
// usage:
//   an action transfer is taken at a rising edge with start high and busy low;
//   i_action selects allocate, free, write byte or read byte, with i_size,
//   i_address and i_wdata as operands
//   every action gives exactly one result transfer: o_valid is high for one
//   cycle with o_status, o_payload_addr and o_rdata; the receiver cannot stall
//   busy drops in the cycle the result is shown, so the next action can go in
// steps, one action at a time:
//   write or failed byte access: latch, then write or refusal; read byte: latch, read, result
//   allocate: a header read and an evaluation per block walked plus 2 or 4 tag writes
//   free: walk as above, one write per cleared byte, 2 tag writes
//   the steps follow from the single read and single write port of the heap
//   store: the walk needs a header read per block, the clear a write per byte
// reset:
//   synchronous, active low; afterwards a clearing pass over every heap byte
//   writes one free block spanning the heap, with busy high all along
module boundary_tag_heap_allocator #(
    parameter int HEAP_BYTES = btha_pkg::HEAP_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [6:0] i_size,
    input  logic [6:0] i_address,
    input  logic [7:0] i_wdata,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [6:0] o_payload_addr,
    output logic [7:0] o_rdata
);

`include "boundary_tag_heap_allocator_macros.svh"

    btha_pkg::t_dp_cmd  cmd;
    btha_pkg::t_dp_stat stat;

    // sequencer: clearing pass, block walk, merge, tag writes, byte accesses
    btha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // heap store plus walk and result registers
    btha_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_action       (i_action),
        .i_size         (i_size),
        .i_address      (i_address),
        .i_wdata        (i_wdata),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_payload_addr (o_payload_addr),
        .o_rdata        (o_rdata)
    );

    // results are single-cycle strobes, never back to back
    `BTHA_ASSERT_NXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid)
    // an accepted action keeps the block busy in the next cycle
    `BTHA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

endmodule

### tb/tb_boundary_tag_heap_allocator.sv
// testbench of the boundary tag heap allocator, checked against a heap image kept in step
module tb_boundary_tag_heap_allocator;
    import btha_pkg::*;

    localparam int HEAP_BYTES     = HEAP_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 3000;   // well above the slowest action plus sender gaps
    localparam int SETTLE_CYCLES  = 300;    // well above the longest allocate or free
    localparam int RANDOM_ITEMS   = 205;    // per idling phase, four phases
    localparam logic [7:0] WHOLE_HEAP_TAG = {7'(HEAP_BYTES), 1'b0};

    // one expected result transfer
    typedef struct {
        t_status    status;
        logic [6:0] payload_addr;
        logic [7:0] rdata;
    } t_heap_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_action;
    logic [6:0] i_size;
    logic [6:0] i_address;
    logic [7:0] i_wdata;
    logic       o_valid;
    logic [1:0] o_status;
    logic [6:0] o_payload_addr;
    logic [7:0] o_rdata;

    // heap image updated at each accepted action, and results still to come
    logic [7:0]   heap_img [HEAP_BYTES];
    t_heap_result pending_results [$];
    int           mismatch_count = 0;
    int           idle_pct = 0;       // chance in percent that the sender skips a cycle
    int           quiet_cycles = 0;   // cycles with no transfer on either side

    always #10 i_clk = ~i_clk;

    boundary_tag_heap_allocator #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_size        (i_size),
        .i_address     (i_address),
        .i_wdata       (i_wdata),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_payload_addr(o_payload_addr),
        .o_rdata       (o_rdata)
    );

    // ---------------------------------------------------------------
    // heap image
    // ---------------------------------------------------------------

    // size of the block with its header at hdr, 0 where the walk must stop
    function automatic int tag_span(input int hdr);
        int span;
        if (hdr >= HEAP_BYTES) return 0;
        span = heap_img[hdr][7:1];
        if (span < 2 || hdr + span > HEAP_BYTES) return 0;
        return span;
    endfunction

    function automatic void put_tags(input int first, input int span, input logic used);
        heap_img[first]            = {7'(span), used};
        heap_img[first + span - 1] = {7'(span), used};
    endfunction

    // applies one action to the image and returns the result it must give
    function automatic t_heap_result apply_action(input t_action act, input logic [6:0] sz,
                                                  input logic [6:0] addr, input logic [7:0] wd);
        t_heap_result res;
        int hdr, span, need, prev, first, last, nxt, b;
        bit has_prev, found;
        res.status       = ST_OK;
        res.payload_addr = '0;
        res.rdata        = '0;
        case (act)
            ACT_ALLOC: begin
                // first fit over the block walk
                need = int'(sz) + 2;
                res.status = ST_NO_FIT;
                hdr = 0;
                span = tag_span(hdr);
                while (span != 0) begin
                    if (!heap_img[hdr][0] && span >= need) begin
                        if (span - need >= 2) begin
                            put_tags(hdr, need, 1'b1);
                            put_tags(hdr + need, span - need, 1'b0);
                        end else begin
                            // remainder too small for a block of its own
                            put_tags(hdr, span, 1'b1);
                        end
                        res.status       = ST_OK;
                        res.payload_addr = 7'(hdr + 1);
                        break;
                    end
                    hdr += span;
                    span = tag_span(hdr);
                end
            end
            ACT_FREE: begin
                hdr = 0;
                prev = 0;
                has_prev = 1'b0;
                found = 1'b0;
                span = tag_span(hdr);
                while (span != 0) begin
                    if (hdr + 1 == int'(addr)) begin
                        found = 1'b1;
                        break;
                    end
                    prev = hdr;
                    has_prev = 1'b1;
                    hdr += span;
                    span = tag_span(hdr);
                end
                if (!found || !heap_img[hdr][0]) begin
                    res.status = ST_BAD_ADDR;
                end else begin
                    // merge with free neighbours and clear the whole interior
                    first = hdr;
                    last = hdr + span;
                    if (has_prev && !heap_img[prev][0]) first = prev;
                    nxt = tag_span(last);
                    if (nxt != 0 && !heap_img[last][0]) last += nxt;
                    for (b = first + 1; b + 1 < last; b++) heap_img[b] = 8'd0;
                    put_tags(first, last - first, 1'b0);
                end
            end
            default: begin
                if (int'(addr) >= HEAP_BYTES) res.status = ST_BAD_ADDR;
                else if (act == ACT_WRITE) heap_img[addr] = wd;
                else res.rdata = heap_img[addr];
            end
        endcase
        return res;
    endfunction

    // allocated blocks on the walk, used to aim frees and byte accesses
    function automatic int count_used();
        int hdr, span, cnt;
        cnt = 0;
        hdr = 0;
        span = tag_span(hdr);
        while (span != 0) begin
            if (heap_img[hdr][0]) cnt++;
            hdr += span;
            span = tag_span(hdr);
        end
        return cnt;
    endfunction

    function automatic int used_hdr(input int nth);
        int hdr, span, cnt;
        cnt = 0;
        hdr = 0;
        span = tag_span(hdr);
        while (span != 0) begin
            if (heap_img[hdr][0]) begin
                if (cnt == nth) return hdr;
                cnt++;
            end
            hdr += span;
            span = tag_span(hdr);
        end
        return 0;
    endfunction

    // true when the walk covers the heap exactly, false after a header got corrupted
    function automatic bit walk_reaches_end();
        int hdr, span;
        hdr = 0;
        span = tag_span(hdr);
        while (span != 0) begin
            hdr += span;
            span = tag_span(hdr);
        end
        return hdr == HEAP_BYTES;
    endfunction

    // ---------------------------------------------------------------
    // action side
    // ---------------------------------------------------------------

    // one action transfer; start may drop on random cycles while waiting for busy low
    task automatic send_item(input t_action act, input logic [6:0] sz,
                             input logic [6:0] addr, input logic [7:0] wd);
        bit drive;
        i_action  <= act;
        i_size    <= sz;
        i_address <= addr;
        i_wdata   <= wd;
        forever begin
            drive = ($urandom_range(0, 99) >= idle_pct);
            start <= drive;
            @(posedge i_clk);
            if (drive && !busy) break;
        end
        pending_results.push_back(apply_action(act, sz, addr, wd));
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // result side: each strobe is checked against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_heap_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no action outstanding, status %0d", o_status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_payload_addr !== want.payload_addr) begin
                    $error("payload_addr: expected %0d, got %0d",
                           want.payload_addr, o_payload_addr);
                    mismatch_count++;
                end
                if (o_rdata !== want.rdata) begin
                    $error("rdata: expected %0d, got %0d", want.rdata, o_rdata);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: a hang shows as a long stretch with no transfer at all
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("FAIL boundary_tag_heap_allocator");
        $finish;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // tags after reset, and byte accesses just past the heap end
    task automatic test_byte_access_limits();
        send_item(ACT_READ, 7'd0, 7'd0, 8'd0);
        send_item(ACT_READ, 7'd0, 7'(HEAP_BYTES - 1), 8'd0);
        send_item(ACT_READ, 7'd0, 7'd127, 8'd0);
        send_item(ACT_WRITE, 7'd0, 7'd127, 8'hFF);
    endtask

    // whole heap, no fit, small remainder handed out, split and exact fit
    task automatic test_alloc_fit_and_split();
        send_item(ACT_ALLOC, 7'd125, 7'd0, 8'd0);
        send_item(ACT_ALLOC, 7'd0, 7'd0, 8'd0);
        send_item(ACT_FREE, 7'd0, 7'd1, 8'd0);
        send_item(ACT_ALLOC, 7'd124, 7'd0, 8'd0);   // one byte left over stays inside
        send_item(ACT_FREE, 7'd0, 7'd1, 8'd0);
        send_item(ACT_ALLOC, 7'd123, 7'd0, 8'd0);   // two bytes left over become a block
        send_item(ACT_ALLOC, 7'd0, 7'd0, 8'd0);     // exact fit into that block
        send_item(ACT_ALLOC, 7'd0, 7'd0, 8'd0);
        send_item(ACT_FREE, 7'd0, 7'd126, 8'd0);    // left neighbour still allocated
        send_item(ACT_FREE, 7'd0, 7'd1, 8'd0);      // merges with the right
        send_item(ACT_FREE, 7'd0, 7'd1, 8'd0);      // now free: bad address
    endtask

    // merging on no side, one side and both sides, plus bad addresses
    task automatic test_free_merging();
        send_item(ACT_ALLOC, 7'd10, 7'd0, 8'd0);
        send_item(ACT_ALLOC, 7'd10, 7'd0, 8'd0);
        send_item(ACT_ALLOC, 7'd10, 7'd0, 8'd0);
        send_item(ACT_FREE, 7'd0, 7'd13, 8'd0);
        send_item(ACT_FREE, 7'd0, 7'd1, 8'd0);
        send_item(ACT_FREE, 7'd0, 7'd25, 8'd0);
        send_item(ACT_FREE, 7'd0, 7'd0, 8'd0);
        send_item(ACT_FREE, 7'd0, 7'd127, 8'd0);
    endtask

    // a written header with size 0 cuts the block list short
    task automatic test_corrupt_header();
        send_item(ACT_WRITE, 7'd0, 7'd0, 8'h00);
        send_item(ACT_ALLOC, 7'd0, 7'd0, 8'd0);
        send_item(ACT_READ, 7'd0, 7'd0, 8'd0);
        send_item(ACT_WRITE, 7'd0, 7'd0, WHOLE_HEAP_TAG);
    endtask

    // mostly well-formed traffic on live blocks, some noise and header damage
    task automatic test_random_traffic(input int pct);
        int n, used, roll, hdr, span;
        logic [6:0] sz, addr;
        drain_results();
        idle_pct = pct;
        // start the phase from one free block over the whole heap
        send_item(ACT_WRITE, 7'($urandom_range(0, 125)), 7'd0, WHOLE_HEAP_TAG);
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (!walk_reaches_end() && $urandom_range(0, 3) == 0)
                send_item(ACT_WRITE, 7'($urandom_range(0, 125)), 7'd0, WHOLE_HEAP_TAG);
            used = count_used();
            roll = $urandom_range(0, 99);
            if (roll < 32) begin
                sz = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 125))
                                                 : 7'($urandom_range(0, 15));
                send_item(ACT_ALLOC, sz, 7'($urandom_range(0, 127)), 8'($urandom));
            end else if (roll < 58) begin
                if (used != 0 && $urandom_range(0, 9) != 0)
                    addr = 7'(used_hdr($urandom_range(0, used - 1)) + 1);
                else
                    addr = 7'($urandom_range(0, 127));
                send_item(ACT_FREE, 7'($urandom_range(0, 125)), addr, 8'($urandom));
            end else begin
                if (used != 0 && $urandom_range(0, 19) != 0) begin
                    // somewhere inside a live payload
                    hdr = used_hdr($urandom_range(0, used - 1));
                    span = tag_span(hdr);
                    addr = 7'(hdr + 1 + $urandom_range(0, (span > 2) ? span - 3 : 0));
                end else begin
                    addr = 7'($urandom_range(0, 127));
                end
                send_item((roll < 80) ? ACT_WRITE : ACT_READ, 7'($urandom_range(0, 125)),
                          addr, 8'($urandom));
            end
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_action  <= ACT_ALLOC;
        i_size    <= '0;
        i_address <= '0;
        i_wdata   <= '0;
        // state after reset: one free block spanning the heap
        heap_img = '{default: 8'd0};
        heap_img[0] = WHOLE_HEAP_TAG;
        heap_img[HEAP_BYTES - 1] = WHOLE_HEAP_TAG;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // busy covers the clearing pass, so the first transfer simply waits

        test_byte_access_limits();
        test_alloc_fit_and_split();
        test_free_merging();
        test_corrupt_header();

        // idling phases; each begins with the sender drained
        test_random_traffic(0);
        test_random_traffic(58);
        test_random_traffic(10);
        test_random_traffic(0);

        drain_results();
        // late or extra strobes would still be caught here
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS boundary_tag_heap_allocator");
        else
            $display("FAIL boundary_tag_heap_allocator");
        $finish;
    end

endmodule
